// File: hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, payload types and stage records for the HSV to RGB
// converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // fixed-point format of saturation, value and outputs
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 15;
    localparam int UNIT_W    = FRAC_BITS + 1;

    // hue geometry in 1/16 degree
    localparam int HUE_FULL      = 5760;
    localparam int HUE_SECTOR    = 960;
    localparam int SECTOR_COUNT  = 6;
    localparam int HUE_BIAS      = SECTOR_COUNT * HUE_FULL;
    localparam int HPOS_W        = 17;
    localparam int SECTOR_SHIFT  = 6;             // 960 = 15 << 6
    localparam int HQ_W          = HPOS_W - SECTOR_SHIFT;
    localparam int REM_W         = 10;
    localparam int SEC_IDX_W     = 7;             // hpos / 960 is at most 70
    localparam int SECTOR_W      = 3;

    // divide by 15 through a reciprocal, exact over the ranges used
    localparam int HUE_DIV_SHIFT = 17;
    localparam int HUE_DIV_MUL   = ((1 << HUE_DIV_SHIFT) + 14) / 15;
    localparam int HQ_MUL_W      = 14;

    // divide by 6 through a reciprocal, exact below 128
    localparam int WRAP_DIV_SHIFT = 8;
    localparam int WRAP_DIV_MUL   = 43;
    localparam int WRAP_MUL_W     = 6;
    localparam int WRAP_Q_W       = 4;

    // fraction within a sector: (rem << FRAC_BITS) / 960
    localparam int SCALED_W    = REM_W + FRAC_BITS - SECTOR_SHIFT;
    localparam int FRAC_SHIFT  = FRAC_BITS + 8;
    localparam int FRAC_MUL    = ((1 << FRAC_SHIFT) + 14) / 15;
    localparam int FRAC_MUL_W  = FRAC_BITS + 5;
    localparam int FRAC_PROD_W = SCALED_W + FRAC_MUL_W;

    // register stages from request to result
    localparam int PIPE_DEPTH = 6;

    // hexcone sectors, 60 degrees each
    localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_MAGENTA_RED   = 3'd5;

    typedef logic [UNIT_W-1:0] unit_t;

    typedef struct packed {
        logic signed [IN_W-1:0] hue;
        logic signed [IN_W-1:0] saturation;
        logic signed [IN_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_t;

    // hue split and clamped channels
    typedef struct packed {
        logic                grey;
        logic [SECTOR_W-1:0] sector;
        logic [REM_W-1:0]    rem;
        unit_t               sat;
        unit_t               val;
    } split_t;

    // the four candidate levels for one color
    typedef struct packed {
        logic                grey;
        logic [SECTOR_W-1:0] sector;
        unit_t               val;
        unit_t               p;
        unit_t               q;
        unit_t               t;
    } mix_t;

    // keep the low output bits of a level
    function automatic logic [OUT_W-1:0] to_out(unit_t x);
        return OUT_W'(x);
    endfunction

endpackage

// File: hdl/hsv2rgb_hue_split.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// Two pipeline stages: clamp saturation and value, wrap the hue and split it
// into a sector index and a remainder within the sector.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hsv2rgb_pkg::hsv_t   pix,
    output logic                out_valid,
    output hsv2rgb_pkg::split_t split
);

    // clamp a signed Q2.14 word to 0..1.0
    function automatic hsv2rgb_pkg::unit_t clamp_unit(
        logic signed [hsv2rgb_pkg::IN_W-1:0] x
    );
        hsv2rgb_pkg::unit_t r;
        if (x < 0)
            r = '0;
        else if (int'(x) > hsv2rgb_pkg::ONE)
            r = hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::ONE);
        else
            r = hsv2rgb_pkg::UNIT_W'($unsigned(x));
        return r;
    endfunction

    logic                                  s1_valid_reg;
    logic [hsv2rgb_pkg::HPOS_W-1:0]        s1_hpos_reg;
    logic [hsv2rgb_pkg::HPOS_W-1:0]        s1_hpos_next;
    logic [hsv2rgb_pkg::SEC_IDX_W-1:0]     s1_idx_reg;
    logic [hsv2rgb_pkg::SEC_IDX_W-1:0]     s1_idx_next;
    hsv2rgb_pkg::unit_t                    s1_sat_reg;
    hsv2rgb_pkg::unit_t                    s1_sat_next;
    hsv2rgb_pkg::unit_t                    s1_val_reg;
    hsv2rgb_pkg::unit_t                    s1_val_next;
    logic [hsv2rgb_pkg::HQ_W+hsv2rgb_pkg::HQ_MUL_W-1:0] hq_prod;

    logic [hsv2rgb_pkg::HPOS_W-1:0]        base_off;
    logic [hsv2rgb_pkg::HPOS_W-1:0]        rem_full;
    logic [hsv2rgb_pkg::SEC_IDX_W+hsv2rgb_pkg::WRAP_MUL_W-1:0] wrap_prod;
    logic [hsv2rgb_pkg::WRAP_Q_W-1:0]      wrap_q;
    logic [hsv2rgb_pkg::SEC_IDX_W-1:0]     sector_full;

    logic                                  valid_reg;
    hsv2rgb_pkg::split_t                   split_reg;
    hsv2rgb_pkg::split_t                   split_next;

    // stage 1: bias hue positive, coarse index = hpos / 960, clamp channels
    always_comb
    begin
        s1_hpos_next = hsv2rgb_pkg::HPOS_W'(int'(pix.hue) + hsv2rgb_pkg::HUE_BIAS);
        hq_prod = (hsv2rgb_pkg::HQ_W + hsv2rgb_pkg::HQ_MUL_W)'(
                      s1_hpos_next[hsv2rgb_pkg::HPOS_W-1:hsv2rgb_pkg::SECTOR_SHIFT])
                  * (hsv2rgb_pkg::HQ_W + hsv2rgb_pkg::HQ_MUL_W)'(hsv2rgb_pkg::HUE_DIV_MUL);
        s1_idx_next = hq_prod[hsv2rgb_pkg::HUE_DIV_SHIFT +: hsv2rgb_pkg::SEC_IDX_W];
        s1_sat_next = clamp_unit(pix.saturation);
        s1_val_next = clamp_unit(pix.brightness);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_hpos_reg <= s1_hpos_next;
        s1_idx_reg  <= s1_idx_next;
        s1_sat_reg  <= s1_sat_next;
        s1_val_reg  <= s1_val_next;
    end

    // stage 2: remainder within sector, sector = index mod 6
    always_comb
    begin
        base_off    = hsv2rgb_pkg::HPOS_W'(s1_idx_reg)
                      * hsv2rgb_pkg::HPOS_W'(hsv2rgb_pkg::HUE_SECTOR);
        rem_full    = s1_hpos_reg - base_off;
        wrap_prod   = (hsv2rgb_pkg::SEC_IDX_W + hsv2rgb_pkg::WRAP_MUL_W)'(s1_idx_reg)
                      * (hsv2rgb_pkg::SEC_IDX_W + hsv2rgb_pkg::WRAP_MUL_W)'(
                          hsv2rgb_pkg::WRAP_DIV_MUL);
        wrap_q      = wrap_prod[hsv2rgb_pkg::WRAP_DIV_SHIFT +: hsv2rgb_pkg::WRAP_Q_W];
        sector_full = s1_idx_reg - hsv2rgb_pkg::SEC_IDX_W'(wrap_q)
                      * hsv2rgb_pkg::SEC_IDX_W'(hsv2rgb_pkg::SECTOR_COUNT);

        split_next.grey   = (s1_sat_reg == '0);
        split_next.sector = sector_full[hsv2rgb_pkg::SECTOR_W-1:0];
        split_next.rem    = rem_full[hsv2rgb_pkg::REM_W-1:0];
        split_next.sat    = s1_sat_reg;
        split_next.val    = s1_val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        split_reg <= split_next;
    end

    assign out_valid = valid_reg;
    assign split     = split_reg;

    // split stays inside one turn of the hexcone
    a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (split_reg.sector <= hsv2rgb_pkg::SEC_MAGENTA_RED)
                      && (int'(split_reg.rem) < hsv2rgb_pkg::HUE_SECTOR))
        else $error("hue split out of range");

endmodule

// File: hdl/hsv2rgb_product.sv
// ----------------------------------------------------------------------------
// hsv2rgb_product
// Three pipeline stages: sector fraction and p, then s*f and s*(1-f),
// then q and t. Every product is truncated to the unit format.
// ----------------------------------------------------------------------------
module hsv2rgb_product
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hsv2rgb_pkg::split_t split,
    output logic                out_valid,
    output hsv2rgb_pkg::mix_t   mix
);

    // (a * b) >> FRAC_BITS for two unit-scaled levels
    function automatic hsv2rgb_pkg::unit_t mul_unit(
        hsv2rgb_pkg::unit_t a,
        hsv2rgb_pkg::unit_t b
    );
        logic [2*hsv2rgb_pkg::UNIT_W-1:0] prod;
        prod = (2*hsv2rgb_pkg::UNIT_W)'(a) * (2*hsv2rgb_pkg::UNIT_W)'(b);
        return prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::UNIT_W];
    endfunction

    // stage a
    logic                                  a_valid_reg;
    logic [hsv2rgb_pkg::FRAC_BITS-1:0]     a_frac_reg;
    logic [hsv2rgb_pkg::FRAC_BITS-1:0]     a_frac_next;
    hsv2rgb_pkg::unit_t                    a_p_reg;
    hsv2rgb_pkg::unit_t                    a_p_next;
    hsv2rgb_pkg::split_t                   a_split_reg;
    logic [hsv2rgb_pkg::SCALED_W-1:0]      scaled;
    logic [hsv2rgb_pkg::FRAC_PROD_W-1:0]   frac_prod;

    // stage b
    logic                                  b_valid_reg;
    hsv2rgb_pkg::unit_t                    b_sf_reg;
    hsv2rgb_pkg::unit_t                    b_sf_next;
    hsv2rgb_pkg::unit_t                    b_scf_reg;
    hsv2rgb_pkg::unit_t                    b_scf_next;
    hsv2rgb_pkg::unit_t                    b_p_reg;
    hsv2rgb_pkg::unit_t                    b_val_reg;
    logic                                  b_grey_reg;
    logic [hsv2rgb_pkg::SECTOR_W-1:0]      b_sector_reg;

    // stage c
    logic                                  valid_reg;
    hsv2rgb_pkg::mix_t                     mix_reg;
    hsv2rgb_pkg::mix_t                     mix_next;

    // stage a: f = (rem << FRAC_BITS) / 960, p = v * (1 - s)
    always_comb
    begin
        scaled = hsv2rgb_pkg::SCALED_W'(split.rem)
                 << (hsv2rgb_pkg::FRAC_BITS - hsv2rgb_pkg::SECTOR_SHIFT);
        frac_prod = hsv2rgb_pkg::FRAC_PROD_W'(scaled)
                    * hsv2rgb_pkg::FRAC_PROD_W'(hsv2rgb_pkg::FRAC_MUL);
        a_frac_next = frac_prod[hsv2rgb_pkg::FRAC_SHIFT +: hsv2rgb_pkg::FRAC_BITS];
        a_p_next = mul_unit(split.val,
                            hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::ONE) - split.sat);
    end

    // stage b: s * f and s * (1 - f)
    always_comb
    begin
        b_sf_next  = mul_unit(a_split_reg.sat, {1'b0, a_frac_reg});
        b_scf_next = mul_unit(a_split_reg.sat,
                              hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::ONE) - {1'b0, a_frac_reg});
    end

    // stage c: q = v * (1 - s f), t = v * (1 - s (1 - f))
    always_comb
    begin
        mix_next.grey   = b_grey_reg;
        mix_next.sector = b_sector_reg;
        mix_next.val    = b_val_reg;
        mix_next.p      = b_p_reg;
        mix_next.q      = mul_unit(b_val_reg,
                                   hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::ONE) - b_sf_reg);
        mix_next.t      = mul_unit(b_val_reg,
                                   hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::ONE) - b_scf_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            valid_reg   <= b_valid_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        a_frac_reg   <= a_frac_next;
        a_p_reg      <= a_p_next;
        a_split_reg  <= split;
        b_sf_reg     <= b_sf_next;
        b_scf_reg    <= b_scf_next;
        b_p_reg      <= a_p_reg;
        b_val_reg    <= a_split_reg.val;
        b_grey_reg   <= a_split_reg.grey;
        b_sector_reg <= a_split_reg.sector;
        mix_reg      <= mix_next;
    end

    assign out_valid = valid_reg;
    assign mix       = mix_reg;

    // no derived level may exceed the value it scales
    a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (mix_reg.p <= mix_reg.val) && (mix_reg.q <= mix_reg.val)
                      && (mix_reg.t <= mix_reg.val))
        else $error("derived level above value");

endmodule

// File: hdl/hsv2rgb_route.sv
// ----------------------------------------------------------------------------
// hsv2rgb_route
// Output stage: steer v, p, q, t onto red, green and blue by sector,
// or v onto all three for grey, and register the result with its strobe.
// ----------------------------------------------------------------------------
module hsv2rgb_route
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  hsv2rgb_pkg::mix_t mix,
    output logic              done,
    output hsv2rgb_pkg::rgb_t result
);

    logic               done_reg;
    hsv2rgb_pkg::rgb_t  result_reg;
    hsv2rgb_pkg::rgb_t  result_next;
    hsv2rgb_pkg::unit_t r_lvl;
    hsv2rgb_pkg::unit_t g_lvl;
    hsv2rgb_pkg::unit_t b_lvl;

    // sector steering
    always_comb
    begin
        case (mix.sector)
            hsv2rgb_pkg::SEC_RED_YELLOW:
            begin
                r_lvl = mix.val; g_lvl = mix.t;   b_lvl = mix.p;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                r_lvl = mix.q;   g_lvl = mix.val; b_lvl = mix.p;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                r_lvl = mix.p;   g_lvl = mix.val; b_lvl = mix.t;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                r_lvl = mix.p;   g_lvl = mix.q;   b_lvl = mix.val;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                r_lvl = mix.t;   g_lvl = mix.p;   b_lvl = mix.val;
            end
            default:
            begin
                r_lvl = mix.val; g_lvl = mix.p;   b_lvl = mix.q;
            end
        endcase

        if (mix.grey)
        begin
            r_lvl = mix.val;
            g_lvl = mix.val;
            b_lvl = mix.val;
        end

        result_next.red   = hsv2rgb_pkg::to_out(r_lvl);
        result_next.green = hsv2rgb_pkg::to_out(g_lvl);
        result_next.blue  = hsv2rgb_pkg::to_out(b_lvl);
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // grey requests leave with equal components
    a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && mix.grey) |=> done_reg && (result_reg.red == result_reg.green)
                                  && (result_reg.green == result_reg.blue))
        else $error("grey request with unequal components");

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to RGB color conversion, fully pipelined, one request per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A request (hue, saturation, brightness) is taken at each rising edge
//   where start is high and busy is low. busy is held low: the pipeline has
//   no back pressure, so a request may be issued in every cycle.
//   Hue is signed degrees with 4 fraction bits, wrapped into 0..360 degrees;
//   saturation and brightness are signed Q2.14, clamped to 0..1.0.
//   Each result (red, green, blue, unsigned Q1.14) is shown for exactly one
//   cycle with done high, in request order. Throughput is one request per
//   cycle; each request passes through six register stages: hue wrap and
//   coarse divide, sector split, fraction and p product, s*f products,
//   q/t products, and the output register.
//   The receiver cannot stall, so results must be taken as they appear.
//   Reset clears only the valid bits; requests in flight are dropped and
//   done stays low until new requests come through.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hsv2rgb_pkg::hsv_t request,
    output logic              done,
    output hsv2rgb_pkg::rgb_t result
);

    logic                accept;
    logic                split_valid;
    hsv2rgb_pkg::split_t split;
    logic                mix_valid;
    hsv2rgb_pkg::mix_t   mix;

    // no back pressure anywhere in the pipeline
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // hue wrap, sector split and clamping
    hsv2rgb_hue_split u_hue_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pix       (request),
        .out_valid (split_valid),
        .split     (split)
    );

    // p, q, t products
    hsv2rgb_product u_product
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .split     (split),
        .out_valid (mix_valid),
        .mix       (mix)
    );

    // sector steering and output register
    hsv2rgb_route u_route
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .mix       (mix),
        .done      (done),
        .result    (result)
    );

    // every result traces back to a request a fixed latency earlier
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, hsv2rgb_pkg::PIPE_DEPTH))
        else $error("result without matching request");

endmodule

// File: tb/hsv_to_rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches the request and result ports of the HSV to RGB converter. It
// computes the expected color for each accepted request, keeps the expected
// colors in order, and compares every strobed result field by field.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker
    import hsv2rgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  hsv_t request,
    input  logic done,
    input  rgb_t result,
    output int   mismatches,
    output int   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    rgb_t expected_colors[$];

    // clamp a signed Q2.14 level to 0..1.0
    function automatic unit_t clamp_level(logic signed [IN_W-1:0] raw);
        if (raw < 0)
            return '0;
        if (raw > ONE)
            return unit_t'(ONE);
        return unit_t'(raw);
    endfunction

    // hexcone conversion with truncated products
    function automatic rgb_t predict_color(hsv_t px);
        int                  hue_wrap;
        int                  rem;
        logic [SECTOR_W-1:0] sector;
        longint              sat;
        longint              val;
        longint              frac;
        longint              p;
        longint              q;
        longint              t;
        longint              r;
        longint              g;
        longint              b;
        rgb_t                color;

        hue_wrap = int'($signed(px.hue)) % HUE_FULL;
        if (hue_wrap < 0)
            hue_wrap += HUE_FULL;
        sat = longint'(clamp_level(px.saturation));
        val = longint'(clamp_level(px.brightness));

        if (sat == 0)
        begin
            // grey
            r = val;
            g = val;
            b = val;
        end
        else
        begin
            sector = SECTOR_W'(hue_wrap / HUE_SECTOR);
            rem    = hue_wrap % HUE_SECTOR;
            frac   = (longint'(rem) << FRAC_BITS) / HUE_SECTOR;
            p = (val * (ONE - sat)) >> FRAC_BITS;
            q = (val * (ONE - ((sat * frac) >> FRAC_BITS))) >> FRAC_BITS;
            t = (val * (ONE - ((sat * (ONE - frac)) >> FRAC_BITS))) >> FRAC_BITS;
            case (sector)
                SEC_RED_YELLOW:   begin r = val; g = t;   b = p;   end
                SEC_YELLOW_GREEN: begin r = q;   g = val; b = p;   end
                SEC_GREEN_CYAN:   begin r = p;   g = val; b = t;   end
                SEC_CYAN_BLUE:    begin r = p;   g = q;   b = val; end
                SEC_BLUE_MAGENTA: begin r = t;   g = p;   b = val; end
                default:          begin r = val; g = p;   b = q;   end
            endcase
        end

        color.red   = OUT_W'(r);
        color.green = OUT_W'(g);
        color.blue  = OUT_W'(b);
        return color;
    endfunction

    // compare strobed results, then record the new request
    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        int   errs;
        errs = mismatches;
        if (!rst_n)
        begin
            expected_colors.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                             result.red, result.green, result.blue);
                    errs++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (result.red !== want.red)
                    begin
                        $display("%0t: red mismatch expected %0d actual %0d", $time,
                                 want.red, result.red);
                        errs++;
                    end
                    if (result.green !== want.green)
                    begin
                        $display("%0t: green mismatch expected %0d actual %0d", $time,
                                 want.green, result.green);
                        errs++;
                    end
                    if (result.blue !== want.blue)
                    begin
                        $display("%0t: blue mismatch expected %0d actual %0d", $time,
                                 want.blue, result.blue);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                expected_colors.push_back(predict_color(request));
            mismatches  <= errs;
            outstanding <= expected_colors.size();
        end
    end

endmodule

// File: tb/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Drives directed and random HSV requests into the converter with random
// gaps on the request side, and leaves prediction and comparison of the
// RGB results to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

    timeunit 1ns;
    timeprecision 1ps;

    import hsv2rgb_pkg::*;

    localparam int ITEMS_PER_PHASE = 300;
    localparam int CYCLE_LIMIT     = 200000;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    hsv_t request;
    logic done;
    rgb_t result;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hsv_to_rgb_converter u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    hsv_to_rgb_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic hsv_t make_pixel(int h, int s, int v);
        hsv_t px;
        px.hue        = IN_W'(h);
        px.saturation = IN_W'(s);
        px.brightness = IN_W'(v);
        return px;
    endfunction

    // mostly in-range levels and hues, some full-range noise
    function automatic hsv_t random_pixel();
        int h;
        int s;
        int v;
        int pick;
        h = ($urandom_range(99) < 70) ? int'($urandom_range(0, HUE_FULL - 1))
                                      : int'($urandom_range(0, 65535));
        pick = $urandom_range(99);
        if (pick < 60)
            s = $urandom_range(0, ONE);
        else if (pick < 70)
            s = 0;
        else
            s = $urandom_range(0, 65535);
        v = ($urandom_range(99) < 75) ? int'($urandom_range(0, ONE))
                                      : int'($urandom_range(0, 65535));
        return make_pixel(h, s, v);
    endfunction

    // issue one request after a random gap
    task automatic send_request(hsv_t px, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= px;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every expected color has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int idle_pct;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sector edges, hue wrap, clamping, grey
        for (int k = 0; k < SECTOR_COUNT; k++)
            send_request(make_pixel(k * HUE_SECTOR, ONE, ONE), 0);
        for (int k = 1; k <= SECTOR_COUNT; k++)
            send_request(make_pixel(k * HUE_SECTOR - 1, 8192, 12000), 0);
        send_request(make_pixel(-32768, ONE, ONE), 0);
        send_request(make_pixel(32767, 12345, 9876), 0);
        send_request(make_pixel(-1, ONE, ONE), 0);
        send_request(make_pixel(-HUE_FULL, 9000, ONE), 0);
        send_request(make_pixel(480, -32768, 10000), 0);
        send_request(make_pixel(1500, 32767, 10000), 0);
        send_request(make_pixel(2500, ONE + 1, ONE + 1), 0);
        send_request(make_pixel(3000, 0, 7777), 0);
        send_request(make_pixel(4000, 1, ONE), 0);
        send_request(make_pixel(5000, ONE, -32768), 0);
        send_request(make_pixel(5500, ONE, 32767), 0);
        send_request(make_pixel(700, 9999, 0), 0);
        send_request(make_pixel(1200, 5000, 1), 0);
        drain_results();

        // random: request gaps at 32 percent, then 47, then none
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 32 : (phase == 1) ? 47 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request(random_pixel(), idle_pct);
            drain_results();
        end

        // let any stray result show up
        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
